// ----- hw/rtl/plhc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plhc_pkg
// Shared types and constants of the pinned/LRU header record store.
// ----------------------------------------------------------------------------
package plhc_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int CAP_W     = 7;
    localparam int TOTAL_W   = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd32;

    // operation codes
    localparam logic [2:0] MODE_PIN    = 3'd0;
    localparam logic [2:0] MODE_UNPIN  = 3'd1;
    localparam logic [2:0] MODE_ERASE  = 3'd2;
    localparam logic [2:0] MODE_LOOKUP = 3'd3;
    localparam logic [2:0] MODE_FILL   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_HIT  = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // header record payload
    typedef struct packed {
        logic [31:0]  version;
        logic [255:0] merkle;
        logic [31:0]  stamp_time;
        logic [31:0]  target_bits;
        logic [31:0]  nonce_value;
    } t_rec;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic match;
        logic exec;
        logic trim;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_trim;
    } t_sts;

endpackage

// ----- hw/rtl/pinned_lru_header_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinned_lru_header_cache_core
// Keyed header record store with pinned entries and capacity-limited LRU.
// ----------------------------------------------------------------------------
// Usage:
//   Drive mode, key and record fields and raise start while busy is low;
//   that edge accepts the transaction and busy rises until it is finished.
//   Each transaction yields one result, shown for one cycle with o_valid:
//   status, the hit record on a lookup hit (else zero), and both totals.
//   Sequence: accept, key match, execute, then one eviction step per
//   evicted entry and a closing step. The result appears in the cycle in
//   which busy falls. Evictions are serialized since each one moves the
//   oldest rank.
//   i_cfg_we/i_cfg_wdata write lru_capacity; write only while idle.
//   Reset empties the store, clears both totals and sets capacity to 32.
//   The receiver cannot stall; o_valid is a single-cycle strobe.
// ----------------------------------------------------------------------------
module pinned_lru_header_cache_core
    import plhc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic [2:0]          i_mode,
    input  logic [63:0]         i_key,
    input  logic signed [31:0]  i_version,
    input  logic [63:0]         i_merkle_word0,
    input  logic [63:0]         i_merkle_word1,
    input  logic [63:0]         i_merkle_word2,
    input  logic [63:0]         i_merkle_word3,
    input  logic [31:0]         i_stamp_time,
    input  logic [31:0]         i_target_bits,
    input  logic [31:0]         i_nonce_value,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_out_version,
    output logic [63:0]         o_out_merkle0,
    output logic [63:0]         o_out_merkle1,
    output logic [63:0]         o_out_merkle2,
    output logic [63:0]         o_out_merkle3,
    output logic [31:0]         o_out_time,
    output logic [31:0]         o_out_bits,
    output logic [31:0]         o_out_nonce,
    output logic [TOTAL_W-1:0]  o_pinned_total,
    output logic [TOTAL_W-1:0]  o_lru_total
);

    t_cmd cmd;
    t_sts sts;
    t_rec rec_in;
    t_rec rec_out;

    // pack input record
    assign rec_in.version     = i_version;
    assign rec_in.merkle      = {i_merkle_word3, i_merkle_word2,
                                 i_merkle_word1, i_merkle_word0};
    assign rec_in.stamp_time  = i_stamp_time;
    assign rec_in.target_bits = i_target_bits;
    assign rec_in.nonce_value = i_nonce_value;

    plhc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    plhc_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_mode         (i_mode),
        .i_key          (i_key),
        .i_rec          (rec_in),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_rec          (rec_out),
        .o_pinned_total (o_pinned_total),
        .o_lru_total    (o_lru_total)
    );

    // unpack result record
    assign o_out_version = rec_out.version;
    assign o_out_merkle0 = rec_out.merkle[63:0];
    assign o_out_merkle1 = rec_out.merkle[127:64];
    assign o_out_merkle2 = rec_out.merkle[191:128];
    assign o_out_merkle3 = rec_out.merkle[255:192];
    assign o_out_time    = rec_out.stamp_time;
    assign o_out_bits    = rec_out.target_bits;
    assign o_out_nonce   = rec_out.nonce_value;

endmodule

// ----- hw/rtl/plhc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plhc_ctrl
// Sequencer: accept, key match, execute, then evict until within capacity.
// ----------------------------------------------------------------------------
module plhc_ctrl
    import plhc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_TRIM  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_TRIM;
            end
            S_TRIM: begin
                if (i_sts.need_trim) begin
                    o_cmd.trim = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/plhc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plhc_dpath
// Slot tags, recency ranks, counters and the record memory.
// ----------------------------------------------------------------------------
module plhc_dpath
    import plhc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_wdata,
    input  logic [2:0]         i_mode,
    input  logic [63:0]        i_key,
    input  t_rec               i_rec,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output t_rec               o_rec,
    output logic [TOTAL_W-1:0] o_pinned_total,
    output logic [TOTAL_W-1:0] o_lru_total
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    // slot tags and ranks
    logic [SLOTS-1:0] r_valid, n_valid;
    logic [SLOTS-1:0] r_pinned, n_pinned;
    logic [63:0]      r_key [SLOTS];
    logic [IW-1:0]    r_rank [SLOTS];
    logic [IW-1:0]    n_rank [SLOTS];
    logic [CW-1:0]    r_pcnt, n_pcnt;
    logic [CW-1:0]    r_lcnt, n_lcnt;
    logic [CAP_W-1:0] r_cap;

    // transaction registers
    logic [2:0]       r_mode;
    logic [63:0]      r_key_in;
    t_rec             r_rec_in;
    logic             r_found;
    logic [IW-1:0]    r_hit_idx;
    logic             r_free_found;
    logic [IW-1:0]    r_free_idx;
    logic             r_armed, n_armed;
    logic             r_hit, n_hit;
    logic [1:0]       r_status, n_status;

    // record memory
    t_rec             mem [SLOTS];
    t_rec             r_rd;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;

    // output registers
    logic             r_o_valid;
    logic [1:0]       r_o_status;
    t_rec             r_o_rec;
    logic [TOTAL_W-1:0] r_o_ptot;
    logic [TOTAL_W-1:0] r_o_ltot;

    logic [SLOTS-1:0] lru;
    logic             m_found, m_free;
    logic [IW-1:0]    m_idx, m_free_idx;
    logic             vic_found;
    logic [IW-1:0]    vic_idx;
    logic [IW-1:0]    oldest;
    logic             hit_p;
    logic [IW-1:0]    hit_r;
    logic [CMPW-1:0]  lcnt_x, cap_x, pcnt_x;

    assign lru    = r_valid & ~r_pinned;
    assign oldest = IW'(r_lcnt - CW'(1));
    assign lcnt_x = CMPW'(r_lcnt);
    assign pcnt_x = CMPW'(r_pcnt);
    assign cap_x  = CMPW'(r_cap);
    assign hit_p  = r_pinned[r_hit_idx];
    assign hit_r  = r_rank[r_hit_idx];

    // compare key against all slots, find lowest match and lowest free slot
    always_comb begin
        m_found    = 1'b0;
        m_idx      = '0;
        m_free     = 1'b0;
        m_free_idx = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (r_valid[j] && (r_key[j] == r_key_in)) begin
                m_found = 1'b1;
                m_idx   = IW'(j);
            end
            if (!r_valid[j]) begin
                m_free     = 1'b1;
                m_free_idx = IW'(j);
            end
        end
    end

    // pick eviction victim: LRU slot holding the oldest rank
    always_comb begin
        vic_found = 1'b0;
        vic_idx   = '0;
        for (int j = 0; j < SLOTS; j++) begin
            if (lru[j] && (r_rank[j] == oldest)) begin
                vic_found = 1'b1;
                vic_idx   = IW'(j);
            end
        end
    end

    assign o_sts.need_trim = r_armed && (lcnt_x > cap_x) && vic_found;

    // execute operation or one eviction step
    always_comb begin
        n_valid   = r_valid;
        n_pinned  = r_pinned;
        n_rank    = r_rank;
        n_pcnt    = r_pcnt;
        n_lcnt    = r_lcnt;
        n_armed   = r_armed;
        n_hit     = r_hit;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_hit_idx;
        if (i_cmd.exec) begin
            n_armed  = 1'b0;
            n_hit    = 1'b0;
            n_status = ST_DONE;
            unique case (r_mode)
                MODE_PIN: begin
                    if (r_found) begin
                        if (!hit_p) begin
                            // leave recency order
                            for (int j = 0; j < SLOTS; j++) begin
                                if (lru[j] && (r_rank[j] > hit_r)) begin
                                    n_rank[j] = r_rank[j] - IW'(1);
                                end
                            end
                            n_rank[r_hit_idx]   = '0;
                            n_lcnt              = (r_lcnt != '0) ? r_lcnt - CW'(1) : r_lcnt;
                            n_pinned[r_hit_idx] = 1'b1;
                            n_pcnt              = r_pcnt + CW'(1);
                        end
                        mem_we = 1'b1;
                    end else if (r_free_found) begin
                        mem_we               = 1'b1;
                        mem_waddr            = r_free_idx;
                        n_valid[r_free_idx]  = 1'b1;
                        n_pinned[r_free_idx] = 1'b1;
                        n_rank[r_free_idx]   = '0;
                        n_pcnt               = r_pcnt + CW'(1);
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                MODE_UNPIN: begin
                    if (r_found && hit_p) begin
                        n_pcnt = (r_pcnt != '0) ? r_pcnt - CW'(1) : r_pcnt;
                        for (int j = 0; j < SLOTS; j++) begin
                            if (lru[j]) begin
                                n_rank[j] = r_rank[j] + IW'(1);
                            end
                        end
                        n_valid[r_hit_idx]  = 1'b1;
                        n_pinned[r_hit_idx] = 1'b0;
                        n_rank[r_hit_idx]   = '0;
                        n_lcnt              = r_lcnt + CW'(1);
                        n_armed             = 1'b1;
                    end
                end
                MODE_ERASE: begin
                    if (r_found) begin
                        if (hit_p) begin
                            n_pcnt = (r_pcnt != '0) ? r_pcnt - CW'(1) : r_pcnt;
                        end else begin
                            for (int j = 0; j < SLOTS; j++) begin
                                if (lru[j] && (r_rank[j] > hit_r)) begin
                                    n_rank[j] = r_rank[j] - IW'(1);
                                end
                            end
                            n_rank[r_hit_idx] = '0;
                            n_lcnt = (r_lcnt != '0) ? r_lcnt - CW'(1) : r_lcnt;
                        end
                        n_valid[r_hit_idx]  = 1'b0;
                        n_pinned[r_hit_idx] = 1'b0;
                    end
                end
                MODE_LOOKUP: begin
                    if (r_found) begin
                        if (!hit_p) begin
                            // move to front
                            for (int j = 0; j < SLOTS; j++) begin
                                if (lru[j] && (r_rank[j] < hit_r)) begin
                                    n_rank[j] = r_rank[j] + IW'(1);
                                end
                            end
                            n_rank[r_hit_idx] = '0;
                        end
                        n_hit    = 1'b1;
                        n_status = ST_HIT;
                    end else begin
                        n_status = ST_MISS;
                    end
                end
                MODE_FILL: begin
                    if (r_found) begin
                        if (!hit_p) begin
                            mem_we = 1'b1;
                            for (int j = 0; j < SLOTS; j++) begin
                                if (lru[j] && (r_rank[j] < hit_r)) begin
                                    n_rank[j] = r_rank[j] + IW'(1);
                                end
                            end
                            n_rank[r_hit_idx] = '0;
                        end
                    end else if (r_free_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_idx;
                        for (int j = 0; j < SLOTS; j++) begin
                            if (lru[j]) begin
                                n_rank[j] = r_rank[j] + IW'(1);
                            end
                        end
                        n_valid[r_free_idx]  = 1'b1;
                        n_pinned[r_free_idx] = 1'b0;
                        n_rank[r_free_idx]   = '0;
                        n_lcnt               = r_lcnt + CW'(1);
                        n_armed              = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.trim) begin
            // evict the least recent entry
            for (int j = 0; j < SLOTS; j++) begin
                if (lru[j] && (r_rank[j] > oldest)) begin
                    n_rank[j] = r_rank[j] - IW'(1);
                end
            end
            n_valid[vic_idx] = 1'b0;
            n_rank[vic_idx]  = '0;
            n_lcnt           = r_lcnt - CW'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_pinned <= '0;
            r_pcnt   <= '0;
            r_lcnt   <= '0;
            r_cap    <= CAP_RESET;
            r_armed  <= 1'b0;
            r_hit    <= 1'b0;
            r_o_valid <= 1'b0;
            for (int j = 0; j < SLOTS; j++) begin
                r_rank[j] <= '0;
            end
        end else begin
            r_valid   <= n_valid;
            r_pinned  <= n_pinned;
            r_pcnt    <= n_pcnt;
            r_lcnt    <= n_lcnt;
            r_armed   <= n_armed;
            r_hit     <= n_hit;
            r_o_valid <= i_cmd.finish;
            r_rank    <= n_rank;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // transaction payload and match results
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_key_in <= i_key;
            r_rec_in <= i_rec;
        end
        if (i_cmd.match) begin
            r_found      <= m_found;
            r_hit_idx    <= m_idx;
            r_free_found <= m_free;
            r_free_idx   <= m_free_idx;
        end
        if (mem_we) begin
            r_key[mem_waddr] <= r_key_in;
        end
        if (i_cmd.finish) begin
            r_o_status <= r_status;
            r_o_rec    <= r_hit ? r_rd : '0;
            r_o_ptot   <= pcnt_x[TOTAL_W-1:0];
            r_o_ltot   <= lcnt_x[TOTAL_W-1:0];
        end
    end

    // record memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= r_rec_in;
        end
        r_rd <= mem[r_hit_idx];
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_rec          = r_o_rec;
    assign o_pinned_total = r_o_ptot;
    assign o_lru_total    = r_o_ltot;

endmodule
